// ----- rtl/core/cse_pkg.sv -----
// cosine similarity engine: shared widths, types and helpers
// no dependencies; imported by every module of the block
package cse_pkg;

    localparam int DATA_W    = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 40;
    localparam int HALF_W    = 20;
    localparam int WIDE_W    = 80;
    localparam int QUO_W     = 30;
    localparam int ROOT_W    = 16;
    localparam int SREM_W    = 17;
    localparam int STEP_W    = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(7);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(QUO_W / 2 - 1);

    localparam logic [DATA_W-1:0] SIM_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [ROOT_W-1:0] ROOT_CAP = {1'b1, {(ROOT_W-1){1'b0}}};

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        t_acc dot;
        t_acc first;
        t_acc second;
    } t_sums;

    typedef struct packed {
        logic  valid;
        t_sums sums;
    } t_queue_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_DIV,
        S_SQRT,
        S_DONE
    } t_back_state;

    // add a product to a running sum, clamp to the sum range
    function automatic t_acc sat_add(input t_acc acc, input logic signed [PROD_W-1:0] p);
        logic [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - PROD_W){p[PROD_W-1]}}, p};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = sum[ACC_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/cse_front.sv -----
// front end: element products and running dot/norm sums
// depends on cse_pkg; hands finished sums to cse_queue
module cse_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [cse_pkg::DATA_W-1:0] i_x,
    input  logic signed [cse_pkg::DATA_W-1:0] i_y,
    input  logic                          i_last,
    input  logic                          i_full,
    output logic                          o_push,
    output cse_pkg::t_sums                o_sums
);
    import cse_pkg::*;

    logic                     r_p_valid;
    logic                     r_p_last;
    logic signed [PROD_W-1:0] r_pxy;
    logic signed [PROD_W-1:0] r_pxx;
    logic signed [PROD_W-1:0] r_pyy;
    t_acc                     r_dot;
    t_acc                     r_first;
    t_acc                     r_second;
    t_acc                     n_dot;
    t_acc                     n_first;
    t_acc                     n_second;
    logic                     advance;

    assign advance = r_p_valid && (!r_p_last || !i_full);
    assign o_ready = !r_p_valid || advance;
    assign o_push  = advance && r_p_last;

    assign n_dot    = sat_add(r_dot, r_pxy);
    assign n_first  = sat_add(r_first, r_pxx);
    assign n_second = sat_add(r_second, r_pyy);

    assign o_sums.dot    = n_dot;
    assign o_sums.first  = n_first;
    assign o_sums.second = n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_dot     <= '0;
            r_first   <= '0;
            r_second  <= '0;
        end else begin
            if (o_ready) begin
                r_p_valid <= i_valid;
            end
            if (advance) begin
                if (r_p_last) begin
                    r_dot    <= '0;
                    r_first  <= '0;
                    r_second <= '0;
                end else begin
                    r_dot    <= n_dot;
                    r_first  <= n_first;
                    r_second <= n_second;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pxy    <= i_x * i_y;
            r_pxx    <= i_x * i_x;
            r_pyy    <= i_y * i_y;
            r_p_last <= i_last;
        end
    end

endmodule

// ----- rtl/core/cse_queue.sv -----
// short queue of finished sums between front and back
// depends on cse_pkg
module cse_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cse_pkg::t_sums      i_sums,
    output logic                o_full,
    input  logic                i_pop,
    output cse_pkg::t_queue_out o_q
);
    import cse_pkg::*;

    t_sums             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    assign o_q.valid = (r_count != '0);
    assign o_q.sums  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_sums;
        end
    end

endmodule

// ----- rtl/core/cse_back.sv -----
// back end: squares, long division and integer root, one vector pair at a time
// depends on cse_pkg; takes sums from cse_queue, owns the result register
module cse_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cse_pkg::t_queue_out         i_q,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cse_pkg::DATA_W-1:0]  o_sim,
    output logic                        o_zero
);
    import cse_pkg::*;

    t_back_state         r_state;
    t_back_state         n_state;
    logic [STEP_W-1:0]   r_step;
    logic [ACC_W-1:0]    r_a;
    logic [ACC_W-1:0]    r_n1;
    logic [ACC_W-1:0]    r_n2;
    logic                r_neg;
    logic                r_zero;
    logic [WIDE_W-1:0]   r_d2;
    logic [WIDE_W-1:0]   r_den;
    logic [WIDE_W-1:0]   r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [SREM_W-1:0]   r_srem;
    logic [ROOT_W-1:0]   r_root;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_sim;
    logic                r_out_zero;

    logic                zero_case;
    logic                dot_zero;
    logic [ACC_W-1:0]    dot_mag;
    logic                out_load;
    logic [ACC_W-1:0]    op_a;
    logic [ACC_W-1:0]    op_b;
    logic [HALF_W-1:0]   half_a;
    logic [HALF_W-1:0]   half_b;
    logic [2*HALF_W-1:0] pp;
    logic [WIDE_W-1:0]   pp_shifted;
    logic [WIDE_W:0]     rem2;
    logic                div_bit;
    logic [SREM_W+1:0]   sq_shift;
    logic [SREM_W+1:0]   sq_trial;
    logic                sq_bit;
    logic [DATA_W-1:0]   sim_val;

    assign zero_case = ($signed(i_q.sums.first) <= 0) || ($signed(i_q.sums.second) <= 0);
    assign dot_zero  = (i_q.sums.dot == '0);
    assign dot_mag   = i_q.sums.dot[ACC_W-1] ? (~i_q.sums.dot + 1'b1) : i_q.sums.dot;

    // partial products over two 20-bit halves
    assign op_a   = r_step[2] ? r_n1 : r_a;
    assign op_b   = r_step[2] ? r_n2 : r_a;
    assign half_a = r_step[1] ? op_a[ACC_W-1:HALF_W] : op_a[HALF_W-1:0];
    assign half_b = r_step[0] ? op_b[ACC_W-1:HALF_W] : op_b[HALF_W-1:0];
    assign pp     = half_a * half_b;

    always_comb begin
        case ({r_step[1], r_step[0]})
            2'b00:   pp_shifted = {{(WIDE_W-2*HALF_W){1'b0}}, pp};
            2'b11:   pp_shifted = {pp, {(2*HALF_W){1'b0}}};
            default: pp_shifted = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
        endcase
    end

    assign rem2    = {r_rem, 1'b0};
    assign div_bit = (rem2 >= {1'b0, r_den});

    assign sq_shift = {r_srem, r_quo[QUO_W-1:QUO_W-2]};
    assign sq_trial = {2'b00, r_root[ROOT_W-2:0], 2'b01};
    assign sq_bit   = (sq_shift >= sq_trial);

    assign sim_val = r_neg ? (~r_root + 1'b1) : (r_root[ROOT_W-1] ? SIM_MAX : r_root);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q.valid) begin
                    n_state = (zero_case || dot_zero) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                if (r_step == MUL_LAST) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = (r_d2 >= r_den) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_step == SQRT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE:  o_pop    = i_q.valid;
            S_DONE:  out_load = !r_out_valid || i_ready;
            default: begin
                o_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state != n_state) ? '0 : r_step + 1'b1;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a    <= dot_mag;
                r_n1   <= i_q.sums.first;
                r_n2   <= i_q.sums.second;
                r_neg  <= i_q.sums.dot[ACC_W-1];
                r_zero <= zero_case;
                r_root <= '0;
                r_d2   <= '0;
                r_den  <= '0;
            end
            S_MUL: begin
                if (r_step[2]) begin
                    r_den <= r_den + pp_shifted;
                end else begin
                    r_d2 <= r_d2 + pp_shifted;
                end
            end
            S_CMP: begin
                r_rem <= r_d2;
                r_quo <= '0;
                if (r_d2 >= r_den) begin
                    r_root <= ROOT_CAP;
                end
            end
            S_DIV: begin
                r_rem  <= div_bit ? WIDE_W'(rem2 - {1'b0, r_den}) : rem2[WIDE_W-1:0];
                r_quo  <= {r_quo[QUO_W-2:0], div_bit};
                r_srem <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_quo  <= {r_quo[QUO_W-3:0], 2'b00};
                r_srem <= sq_bit ? SREM_W'(sq_shift - sq_trial) : sq_shift[SREM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], sq_bit};
            end
            default: begin
                if (out_load) begin
                    r_out_sim  <= sim_val;
                    r_out_zero <= r_zero;
                end
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_sim   = r_out_sim;
    assign o_zero  = r_out_zero;

endmodule

// ----- rtl/core/cosine_similarity_engine.sv -----
// Cosine similarity of two streamed Q1.15 vectors. One element pair is taken per cycle
// and summed into dot and norm accumulators; the beat with tlast closes the vector pair
// and its sums pass through a two-entry queue to a sequential back end that forms
// |dot|^2 and the norm product with one shared 20x20 multiplier, compares them, runs a
// one-bit-per-cycle long division and a two-bit-per-cycle integer root. The back end
// takes one vector pair at a time; it skips the division and root when |dot|^2 reaches
// the norm product and all arithmetic when a norm or the dot product is zero, and it
// waits while the output stalls. The front end keeps taking elements meanwhile and
// stalls only when two finished pairs already wait in the queue. The result is
// truncated toward zero and saturated; tuser flags a zero norm.
module cosine_similarity_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // x_value[15:0], y_value[31:16]
    input  logic        i_s_axis_tlast,   // last_element
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // similarity[15:0]
    output logic        o_m_axis_tuser    // zero_norm
);
    import cse_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    t_sums      q_sums;
    t_queue_out q_out;

    cse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_x     (i_s_axis_tdata[DATA_W-1:0]),
        .i_y     (i_s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_last  (i_s_axis_tlast),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_sums  (q_sums)
    );

    cse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_sums  (q_sums),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_q     (q_out)
    );

    cse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_out),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_sim   (o_m_axis_tdata),
        .o_zero  (o_m_axis_tuser)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("sums pushed into a full queue");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_out.valid)
        else $error("back end popped an empty queue");

    a_zero_norm_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("zero norm beat with nonzero similarity");

endmodule

// ----- bench/cosine_similarity_checker.sv -----
// cosine similarity engine checker: watches both stream channels, predicts each result
// from the accepted element beats and compares it with the output beats
// depends on cse_pkg for the sum type
module cosine_similarity_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // x_value[15:0], y_value[31:16]
    input  logic        i_s_tlast,   // last_element
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // similarity[15:0]
    input  logic        i_m_tuser,   // zero_norm
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cse_pkg::*;

    typedef struct packed {
        logic [15:0] similarity;
        logic        zero_norm;
    } t_cosine;

    localparam longint SUM_MAX = 64'sd549755813887;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    t_acc    dot_run;
    t_acc    x_energy;
    t_acc    y_energy;
    t_cosine awaited[$];
    int      error_count = 0;
    int      pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic t_acc clamp_add(input t_acc acc, input longint term);
        longint total;
        total = longint'(acc) + term;
        if (total > SUM_MAX) begin
            return t_acc'(SUM_MAX);
        end
        if (total < SUM_MIN) begin
            return t_acc'(SUM_MIN);
        end
        return t_acc'(total);
    endfunction

    // largest q with q^2 * ex * ey <= dot^2 * 2^30, signed and clamped to q1.15
    function automatic t_cosine cosine_of(input t_acc dot, input t_acc ex, input t_acc ey);
        logic [39:0]  mag;
        logic [127:0] num;
        logic [127:0] den;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        t_cosine      r;
        r.similarity = '0;
        r.zero_norm  = 1'b0;
        if (ex <= 0 || ey <= 0) begin
            r.zero_norm = 1'b1;
        end else if (dot != 0) begin
            mag = (dot < 0) ? -dot : dot;
            num = (128'(mag) * 128'(mag)) << 30;
            den = 128'($unsigned(ex)) * 128'($unsigned(ey));
            lo  = 0;
            hi  = 32768;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (den * 128'(mid * mid) <= num) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            if (dot > 0) begin
                r.similarity = (lo > 32767) ? 16'h7fff : 16'(lo);
            end else begin
                r.similarity = 16'(-int'(lo));
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic signed [15:0] xv;
        logic signed [15:0] yv;
        t_cosine            got;
        t_cosine            want;
        if (!i_rst_n) begin
            dot_run  = '0;
            x_energy = '0;
            y_energy = '0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                xv       = i_s_tdata[15:0];
                yv       = i_s_tdata[31:16];
                dot_run  = clamp_add(dot_run, longint'(xv) * longint'(yv));
                x_energy = clamp_add(x_energy, longint'(xv) * longint'(xv));
                y_energy = clamp_add(y_energy, longint'(yv) * longint'(yv));
                if (i_s_tlast) begin
                    awaited.insert(awaited.size(), cosine_of(dot_run, x_energy, y_energy));
                    dot_run  = '0;
                    x_energy = '0;
                    y_energy = '0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.similarity = i_m_tdata;
                got.zero_norm  = i_m_tuser;
                if (awaited.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected beat, actual sim %0d zero %0b", $time,
                             $signed(got.similarity), got.zero_norm);
                end else begin
                    want = awaited.pop_front();
                    if (got.similarity !== want.similarity) begin
                        error_count++;
                        $display("%0t: similarity expected %0d actual %0d", $time,
                                 $signed(want.similarity), $signed(got.similarity));
                    end
                    if (got.zero_norm !== want.zero_norm) begin
                        error_count++;
                        $display("%0t: zero_norm expected %0b actual %0b", $time,
                                 want.zero_norm, got.zero_norm);
                    end
                end
            end
        end
        pending_count = awaited.size();
    end

endmodule

// ----- bench/cosine_similarity_engine_tb.sv -----
// cosine similarity engine testbench top: clock, reset, element stimulus and output stalls
// depends on cosine_similarity_engine and cosine_similarity_checker
module cosine_similarity_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        SHAPE_MIXED,
        SHAPE_SAME,
        SHAPE_OPPOSITE,
        SHAPE_SCALED,
        SHAPE_X_ZERO,
        SHAPE_Y_ZERO,
        SHAPE_BOTH_ZERO
    } t_shape;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_data;
    logic        m_user;
    logic        quiet;
    int          idle_odds;
    int          beats_sent;
    int          errors;
    int          pending;

    cosine_similarity_engine dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    cosine_similarity_checker checker_i (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .i_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tlast  (s_last),
        .i_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .i_m_tdata  (m_data),
        .i_m_tuser  (m_user),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [15:0] x, input logic [15:0] y, input logic last);
        if (!quiet && $urandom_range(0, 7) < idle_odds) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {y, x};
        s_last  <= last;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len, input t_shape shape);
        logic [15:0] x;
        logic [15:0] y;
        for (int i = 0; i < len; i++) begin
            x = pick_value();
            y = pick_value();
            case (shape)
                SHAPE_SAME:      y = x;
                SHAPE_OPPOSITE:  y = -x;
                SHAPE_SCALED:    y = $signed(x) >>> $urandom_range(0, 8);
                SHAPE_X_ZERO:    x = '0;
                SHAPE_Y_ZERO:    y = '0;
                SHAPE_BOTH_ZERO: begin
                    x = '0;
                    y = '0;
                end
                default: ;
            endcase
            send_beat(x, y, i == len - 1);
        end
    endtask

    initial begin
        int     start;
        int     pick;
        int     len;
        t_shape shape;
        rst_n      = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        s_last     = 1'b0;
        quiet      = 1'b0;
        idle_odds  = 0;
        beats_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full scale agreement saturates, full scale opposition does not
        send_beat(16'h7fff, 16'h7fff, 1'b1);
        send_beat(16'h8000, 16'h8000, 1'b1);
        send_beat(16'h8000, 16'h7fff, 1'b1);
        // zero norms on either or both sides
        send_beat(16'h0000, 16'h0000, 1'b1);
        send_beat(16'h0000, 16'd12345, 1'b1);
        send_beat(-16'sd5, 16'h0000, 1'b1);
        // orthogonal vectors, then a nearly opposite pair and a long nearly orthogonal pair
        send_beat(16'h0001, 16'h0000, 1'b0);
        send_beat(16'h0000, 16'h0001, 1'b1);
        send_beat(16'h7fff, 16'h8000, 1'b0);
        send_beat(16'h8000, 16'h7fff, 1'b1);
        for (int i = 0; i < 14; i++) begin
            send_beat(i[0] ? 16'h8000 : 16'h7fff, i[1] ? 16'hffff : 16'h0001, i == 13);
        end

        start = beats_sent;
        while (beats_sent - start < 480) begin
            if (beats_sent - start >= 410) begin
                quiet <= 1'b1;
            end
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            pick = $urandom_range(0, 15);
            if (pick <= 8) begin
                shape = SHAPE_MIXED;
            end else if (pick == 9) begin
                shape = SHAPE_SAME;
            end else if (pick == 10) begin
                shape = SHAPE_OPPOSITE;
            end else if (pick <= 12) begin
                shape = SHAPE_SCALED;
            end else if (pick == 13) begin
                shape = SHAPE_X_ZERO;
            end else if (pick == 14) begin
                shape = SHAPE_Y_ZERO;
            end else begin
                shape = SHAPE_BOTH_ZERO;
            end
            send_vector(len, shape);
        end

        s_valid <= 1'b0;
        s_last  <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // output stalls in bursts, held ready once the run winds down
    initial begin
        int   burst;
        logic level;
        m_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            burst = $urandom_range(1, 17);
            level = quiet ? 1'b1 : ($urandom_range(0, 2) != 0);
            repeat (burst) begin
                @(negedge clk);
                m_ready <= level;
            end
        end
    end

endmodule
